>>> design/tcu_pkg.sv
// Shared types, constants and helper functions for the three-channel timer unit.
package tcu_pkg;

   localparam int TCU_MAX_CHANNELS = 3;
   localparam int TCU_NUM_CHANNELS = 3;

   // request kinds
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   // per-channel register selects
   localparam logic [1:0] REG_TCOR = 2'd0;
   localparam logic [1:0] REG_TCNT = 2'd1;
   localparam logic [1:0] REG_TCR  = 2'd2;
   localparam logic [1:0] REG_NONE = 2'd3;

   localparam logic [31:0] ADDR_TOCR    = 32'hFFD8_0000;
   localparam logic [31:0] ADDR_TSTR    = 32'hFFD8_0004;
   localparam logic [23:0] ADDR_PAGE    = 24'hFFD800;
   localparam logic [7:0]  CHAN_LO_BYTE = 8'h08;
   localparam logic [7:0]  CHAN_HI_BYTE = 8'h2C;
   localparam logic [31:0] ADDR_FORCE   = 32'hF000_0000;

   localparam int TCR_MODE_HI   = 2;
   localparam int TCR_UNIE_BIT  = 5;
   localparam int TCR_UNF_BIT   = 8;
   localparam int TCR_ICPF_BIT  = 9;
   localparam logic [2:0] MODE_MAX = 3'd4;

   localparam logic [31:0] COUNT_RESET  = 32'hFFFF_FFFF;
   localparam logic [31:0] RELOAD_RESET = 32'hFFFF_FFFF;

   typedef struct packed {
      logic       tocr_hit;
      logic       tstr_hit;
      logic       chan_hit;
      logic [1:0] chan;
      logic [1:0] reg_sel;
   } tcu_dec_type;

   typedef struct packed {
      logic wr_tcor;
      logic wr_tcnt;
      logic wr_tcr;
      logic tick;
   } tcu_cmd_type;

   typedef struct packed {
      logic       ok;
      logic [1:0] chan;
      logic [1:0] reg_sel;
   } tcu_word_type;

   // word offset from the first TCOR: channel = word / 3, register = word % 3
   function automatic tcu_word_type tcu_word_map(input logic [3:0] word);
      tcu_word_type m;
      m.ok = 1'b1;
      case (word)
         4'd0: begin m.chan = 2'd0; m.reg_sel = REG_TCOR; end
         4'd1: begin m.chan = 2'd0; m.reg_sel = REG_TCNT; end
         4'd2: begin m.chan = 2'd0; m.reg_sel = REG_TCR;  end
         4'd3: begin m.chan = 2'd1; m.reg_sel = REG_TCOR; end
         4'd4: begin m.chan = 2'd1; m.reg_sel = REG_TCNT; end
         4'd5: begin m.chan = 2'd1; m.reg_sel = REG_TCR;  end
         4'd6: begin m.chan = 2'd2; m.reg_sel = REG_TCOR; end
         4'd7: begin m.chan = 2'd2; m.reg_sel = REG_TCNT; end
         4'd8: begin m.chan = 2'd2; m.reg_sel = REG_TCR;  end
         default: begin m.ok = 1'b0; m.chan = 2'd0; m.reg_sel = REG_NONE; end
      endcase
      return m;
   endfunction

   // prescaler bits that must be zero for a count in the given mode
   function automatic logic [11:0] tcu_mode_mask(input logic [2:0] mode);
      logic [11:0] m;
      case (mode)
         3'd0: m = 12'h00F;
         3'd1: m = 12'h03F;
         3'd2: m = 12'h0FF;
         3'd3: m = 12'h3FF;
         3'd4: m = 12'hFFF;
         default: m = 12'hFFF;
      endcase
      return m;
   endfunction

endpackage

>>> design/tcu_decode.sv
// Bus address decoder for the timer register map.
module tcu_decode #(
   parameter int NUM_CHANNELS = tcu_pkg::TCU_NUM_CHANNELS
) (
   input  logic [31:0]          address,
   output tcu_pkg::tcu_dec_type dec
);
   import tcu_pkg::*;

   logic [31:0]  full_addr;
   logic [7:0]   low_byte;
   logic [3:0]   word;
   logic         in_window;
   tcu_word_type wmap;

   assign full_addr = address | ADDR_FORCE;
   assign low_byte  = full_addr[7:0];
   assign word      = low_byte[5:2] - CHAN_LO_BYTE[5:2];
   assign wmap      = tcu_word_map(word);

   assign in_window = (full_addr[31:8] == ADDR_PAGE) && (low_byte >= CHAN_LO_BYTE)
                      && (low_byte <= CHAN_HI_BYTE) && (low_byte[1:0] == 2'b00);

   always_comb begin
      dec.tocr_hit = (full_addr == ADDR_TOCR);
      dec.tstr_hit = (full_addr == ADDR_TSTR);
      dec.chan_hit = in_window && wmap.ok && (32'(wmap.chan) < 32'(NUM_CHANNELS));
      dec.chan     = wmap.chan;
      dec.reg_sel  = wmap.reg_sel;
   end

endmodule

>>> design/tcu_channel.sv
// One timer channel: down-counter, reload register and control register.
module tcu_channel (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  tcu_pkg::tcu_cmd_type cmd,
   input  logic [31:0]          write_data,
   input  logic [11:0]          prescale_in,
   output logic [31:0]          count_q,
   output logic [15:0]          ctrl_q,
   output logic                 irq_in
);
   import tcu_pkg::*;

   logic [31:0] count_ff, count_in;
   logic [31:0] reload_ff, reload_in;
   logic [15:0] ctrl_ff, ctrl_in;
   logic [15:0] tcr_wr;
   logic [2:0]  mode;
   logic        count_now;

   assign mode      = ctrl_ff[TCR_MODE_HI:0];
   assign count_now = cmd.tick && (mode <= MODE_MAX)
                      && ((prescale_in & tcu_mode_mask(mode)) == 12'h000);

   always_comb begin
      tcr_wr = write_data[15:0];
      if (tcr_wr[TCR_UNF_BIT] && tcr_wr[TCR_ICPF_BIT]) begin
         tcr_wr = {8'h00, tcr_wr[7:0]};
      end
      count_in  = count_ff;
      reload_in = reload_ff;
      ctrl_in   = ctrl_ff;
      if (cmd.wr_tcor) begin
         reload_in = write_data;
      end
      if (cmd.wr_tcnt) begin
         count_in = write_data;
      end
      if (cmd.wr_tcr) begin
         ctrl_in = tcr_wr;
      end
      if (count_now) begin
         if (count_ff == 32'h0) begin
            count_in              = reload_ff;
            ctrl_in[TCR_UNF_BIT]  = 1'b1;
         end else begin
            count_in = count_ff - 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= COUNT_RESET;
         reload_ff <= RELOAD_RESET;
         ctrl_ff   <= 16'h0000;
      end else if (go) begin
         count_ff  <= count_in;
         reload_ff <= reload_in;
         ctrl_ff   <= ctrl_in;
      end
   end

   assign count_q = count_ff;
   assign ctrl_q  = ctrl_ff;
   assign irq_in  = ctrl_in[TCR_UNF_BIT] && ctrl_in[TCR_UNIE_BIT];

endmodule

>>> design/three_channel_timer_unit.sv
// Top level of the three-channel down-counter timer unit.
//
//  channel | direction | ports                                         | handshake
//  --------+-----------+-----------------------------------------------+----------------------
//  req     | in        | req_kind, req_address, req_write_data         | req_valid / req_ready
//  rsp     | out       | rsp_read_data, rsp_read_ok, rsp_irq_lines     | rsp_valid / rsp_ready
//
//  A request is accepted into the input register, its state update and response
//  are formed there and written into the response register, which drives
//  rsp_valid; one request per cycle sustained while rsp_ready stays high.
//  Reset (synchronous, active high) empties both stages and restores the start, prescaler and channel registers.
//  A stalled response holds in its register; one more request can still be
//  taken into the input register behind it before req_ready drops.
module three_channel_timer_unit #(
   parameter int NUM_CHANNELS = tcu_pkg::TCU_NUM_CHANNELS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_address,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic        rsp_read_ok,
   output logic [2:0]  rsp_irq_lines
);
   import tcu_pkg::*;

   // input stage
   logic        in_valid_ff, in_valid_in;
   logic [1:0]  in_kind_ff;
   logic [31:0] in_addr_ff;
   logic [31:0] in_data_ff;

   // response stage
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic        rsp_ok_ff, rsp_ok_in;
   logic [2:0]  rsp_irq_ff, rsp_irq_in;

   // shared state
   logic [31:0] start_ff, start_in;
   logic [11:0] prescale_ff, prescale_in;

   logic        go;
   logic        is_write, is_read, is_tick;
   tcu_dec_type dec;
   tcu_cmd_type cmd [TCU_MAX_CHANNELS];
   logic [31:0] ch_count [TCU_MAX_CHANNELS];
   logic [15:0] ch_ctrl  [TCU_MAX_CHANNELS];
   logic [2:0]  ch_irq;

   // advance the input stage whenever the response register is free or draining
   assign go        = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || go;

   assign is_write = (in_kind_ff == KIND_WRITE);
   assign is_read  = (in_kind_ff == KIND_READ);
   assign is_tick  = (in_kind_ff == KIND_TICK);

   tcu_decode #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) u_decode (
      .address(in_addr_ff),
      .dec    (dec)
   );

   // shared prescaler and start register
   always_comb begin
      prescale_in = prescale_ff;
      if (is_tick) begin
         prescale_in = prescale_ff + 12'd1;
      end
      start_in = start_ff;
      if (is_write && dec.tstr_hit) begin
         start_in = in_data_ff;
      end
      // TOCR writes decode but drive nothing in this block: drop them
   end

   // per-channel commands and channel instances; absent channels read as zero
   for (genvar c = 0; c < TCU_MAX_CHANNELS; c++) begin : g_chan
      if (c < NUM_CHANNELS) begin : g_on
         logic chan_wr;
         assign chan_wr        = is_write && dec.chan_hit && (dec.chan == 2'(c));
         assign cmd[c].wr_tcor = chan_wr && (dec.reg_sel == REG_TCOR);
         assign cmd[c].wr_tcnt = chan_wr && (dec.reg_sel == REG_TCNT);
         assign cmd[c].wr_tcr  = chan_wr && (dec.reg_sel == REG_TCR);
         assign cmd[c].tick    = is_tick && start_ff[c];

         tcu_channel u_channel (
            .clock      (clock),
            .reset      (reset),
            .go         (go),
            .cmd        (cmd[c]),
            .write_data (in_data_ff),
            .prescale_in(prescale_in),
            .count_q    (ch_count[c]),
            .ctrl_q     (ch_ctrl[c]),
            .irq_in     (ch_irq[c])
         );
      end else begin : g_off
         assign cmd[c]      = '0;
         assign ch_count[c] = 32'h0;
         assign ch_ctrl[c]  = 16'h0;
         assign ch_irq[c]   = 1'b0;
      end
   end

   // response: read mux and interrupt lines as they stand after this request
   always_comb begin
      rsp_data_in = 32'h0;
      rsp_ok_in   = 1'b0;
      if (is_read) begin
         if (dec.tstr_hit) begin
            rsp_data_in = start_ff;
            rsp_ok_in   = 1'b1;
         end else if (dec.chan_hit) begin
            case (dec.reg_sel)
               REG_TCNT: begin
                  rsp_data_in = ch_count[dec.chan];
                  rsp_ok_in   = 1'b1;
               end
               REG_TCR: begin
                  rsp_data_in = {16'h0000, ch_ctrl[dec.chan]};
                  rsp_ok_in   = 1'b1;
               end
               default: begin
                  rsp_data_in = 32'h0;
                  rsp_ok_in   = 1'b0;
               end
            endcase
         end
      end
      rsp_irq_in = ch_irq;
   end

   // handshake bookkeeping for both stages
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         start_ff     <= 32'h0;
         prescale_ff  <= 12'h000;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (go) begin
            start_ff    <= start_in;
            prescale_ff <= prescale_in;
         end
      end
   end

   // payload registers: load on acceptance, hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_kind_ff <= req_kind;
         in_addr_ff <= req_address;
         in_data_ff <= req_write_data;
      end
      if (go) begin
         rsp_data_ff <= rsp_data_in;
         rsp_ok_ff   <= rsp_ok_in;
         rsp_irq_ff  <= rsp_irq_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_read_ok   = rsp_ok_ff;
   assign rsp_irq_lines = rsp_irq_ff;

endmodule
